@@ sv/rmq_pkg.sv @@
// Shared types, constants and helpers for the rotation-matrix-to-quaternion core.
`default_nettype none
package rmq_pkg;
   localparam int FRAC_BITS = 14;
   localparam int ELEM_W = 16;
   // Radicand r is at most 3*32767+ONE+... fits 19 bits unsigned; r << F fits 19+F bits.
   localparam int R_W = 19;
   localparam int RAD_W = R_W + FRAC_BITS;          // 33
   localparam int ROOT_W = (RAD_W + 1) / 2;         // 17
   localparam int SQ_STEPS = ROOT_W;                // one root bit per cell
   localparam int NUM_W = 18;                       // signed numerator width
   localparam int DIV_N_W = NUM_W - 1 + FRAC_BITS;  // magnitude << F, 31 bits
   localparam int DEN_W = ROOT_W + 1;               // S = 2 * root
   localparam int DIV_STEPS = DIV_N_W;              // one quotient bit per cell
   localparam int Q_W = DIV_N_W + 1;

   // Per-item payload carried along the chain.
   typedef struct packed {
      logic [1:0]                    big;
      logic [2:0][NUM_W-1:0]         num;   // the three non-big numerators, k order
      logic [RAD_W-1:0]              rem;   // square-root remainder
      logic [ROOT_W-1:0]             root;  // square-root partial result
   } sq_data_type;

   typedef struct packed {
      logic [1:0]                    big;
      logic [ROOT_W-1:0]             root;
      logic [2:0]                    neg;
      logic [2:0][DEN_W:0]           rem;   // partial remainders
      logic [2:0][DIV_N_W-1:0]       quo;   // quotient bits in, dividend bits out
   } dv_data_type;

   // Saturate a signed value to 16 bits.
   function automatic logic [ELEM_W-1:0] sat16(input logic signed [Q_W:0] v);
      logic [ELEM_W-1:0] r;
      if (v > $signed((Q_W+1)'(32767))) r = 16'h7FFF;
      else if (v < -$signed((Q_W+1)'(32768))) r = 16'h8000;
      else r = v[ELEM_W-1:0];
      return r;
   endfunction
endpackage
`default_nettype wire

@@ sv/rmq_sqrt_cell.sv @@
// One stage of the restoring square root: resolves one root bit.
`default_nettype none
module rmq_sqrt_cell (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 en,
   input  wire                 valid_in,
   input  wire [4:0]           step,
   input  rmq_pkg::sq_data_type d_in,
   output logic                valid_ff,
   output rmq_pkg::sq_data_type d_ff
);
   // Digit-by-digit root; rem holds the radicand with consumed bits replaced by remainder.
   rmq_pkg::sq_data_type d_in_next;
   logic [rmq_pkg::RAD_W+1:0] trial;
   logic [rmq_pkg::RAD_W+1:0] cand;
   logic [rmq_pkg::RAD_W+1:0] shifted;
   always_comb begin
      d_in_next = d_in;
      // Candidate (4*root+1) placed at bit 2*step.
      cand = ({{(rmq_pkg::RAD_W+2-rmq_pkg::ROOT_W-2){1'b0}}, d_in.root, 2'b01})
             << (2 * step);
      shifted = {2'b00, d_in.rem};
      trial = shifted - cand;
      if (shifted >= cand) begin
         d_in_next.rem  = trial[rmq_pkg::RAD_W-1:0];
         d_in_next.root = {d_in.root[rmq_pkg::ROOT_W-2:0], 1'b1};
      end else begin
         d_in_next.root = {d_in.root[rmq_pkg::ROOT_W-2:0], 1'b0};
      end
   end
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (en) valid_ff <= valid_in;
      if (en) d_ff <= d_in_next;
   end
endmodule
`default_nettype wire

@@ sv/rmq_div_cell.sv @@
// One stage of three parallel restoring dividers: one quotient bit each.
`default_nettype none
module rmq_div_cell (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 en,
   input  wire                 valid_in,
   input  rmq_pkg::dv_data_type d_in,
   output logic                valid_ff,
   output rmq_pkg::dv_data_type d_ff
);
   rmq_pkg::dv_data_type d_in_next;
   logic [rmq_pkg::DEN_W:0] part;
   logic [rmq_pkg::DEN_W:0] den;
   always_comb begin
      d_in_next = d_in;
      den = {1'b0, d_in.root, 1'b0};
      for (int k = 0; k < 3; k++) begin
         // Shift in the next dividend bit, try to subtract the divisor.
         part = {d_in.rem[k][rmq_pkg::DEN_W-1:0], d_in.quo[k][rmq_pkg::DIV_N_W-1]};
         if (part >= den) begin
            d_in_next.rem[k] = part - den;
            d_in_next.quo[k] = {d_in.quo[k][rmq_pkg::DIV_N_W-2:0], 1'b1};
         end else begin
            d_in_next.rem[k] = part;
            d_in_next.quo[k] = {d_in.quo[k][rmq_pkg::DIV_N_W-2:0], 1'b0};
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (en) valid_ff <= valid_in;
      if (en) d_ff <= d_in_next;
   end
endmodule
`default_nettype wire

@@ sv/rotation_matrix_to_quaternion_core.sv @@
// Top level: rotation matrix to quaternion, pipelined chain of root and divide cells.
//
//   channel | direction | tdata fields (low bit up)
//   req_    | in        | m00 m01 m02 m10 m11 m12 m20 m21 m22 (9 x 16 bits)
//   rsp_    | out       | q_w q_x q_y q_z (4 x 16 bits)
//
// One item enters per cycle while the output is not stalled; the path is the input register,
// 17 root cells, 31 divide cells and the output register: one cell per root bit and per quotient bit.
// Reset clears every valid flag in the chain. A stalled output freezes the whole chain,
// and req_tready then drops only while the output register holds an untaken item.
`default_nettype none
module rotation_matrix_to_quaternion_core (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [143:0] req_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [63:0]  rsp_tdata    // q_w, q_x, q_y, q_z
);
   localparam int NS = rmq_pkg::SQ_STEPS;
   localparam int ND = rmq_pkg::DIV_STEPS;

   logic en;
   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // Front end: branch select, radicand and numerators.
   logic signed [17:0] e [9];
   logic signed [17:0] tr, r, n_a, n_b, n_c, n_d, n_e, n_f;
   logic signed [17:0] one;
   rmq_pkg::sq_data_type front;
   always_comb begin
      for (int i = 0; i < 9; i++) e[i] = 18'(signed'(req_tdata[16*i +: 16]));
      one = 18'(1 << rmq_pkg::FRAC_BITS);
      tr = e[0] + e[4] + e[8];
      n_a = e[7] - e[5];  // m21-m12
      n_b = e[2] - e[6];  // m02-m20
      n_c = e[3] - e[1];  // m10-m01
      n_d = e[1] + e[3];  // m01+m10
      n_e = e[2] + e[6];  // m02+m20
      n_f = e[5] + e[7];  // m12+m21
      front = '0;
      if (tr > 0) begin
         r = tr + one; front.big = 2'd0;
         front.num = {n_c, n_b, n_a};
      end else if (e[0] > e[4] && e[0] > e[8]) begin
         r = one + e[0] - e[4] - e[8]; front.big = 2'd1;
         front.num = {n_e, n_d, n_a};
      end else if (e[4] > e[8]) begin
         r = one + e[4] - e[0] - e[8]; front.big = 2'd2;
         front.num = {n_f, n_d, n_b};
      end else begin
         r = one + e[8] - e[0] - e[4]; front.big = 2'd3;
         front.num = {n_f, n_e, n_c};
      end
      if (r < 0) r = '0;
      front.rem = rmq_pkg::RAD_W'({r[17:0], {rmq_pkg::FRAC_BITS{1'b0}}});
   end

   logic in_v_ff;
   rmq_pkg::sq_data_type in_d_ff;
   always_ff @(posedge clock) begin
      if (reset) in_v_ff <= 1'b0;
      else if (en) in_v_ff <= req_tvalid;
      if (en) in_d_ff <= front;
   end

   // Square-root chain.
   logic sv_c [NS+1];
   rmq_pkg::sq_data_type sd_c [NS+1];
   assign sv_c[0] = in_v_ff;
   assign sd_c[0] = in_d_ff;
   for (genvar g = 0; g < NS; g++) begin : g_sq
      rmq_sqrt_cell u_cell (
         .clock(clock), .reset(reset), .en(en), .valid_in(sv_c[g]),
         .step(5'(NS - 1 - g)), .d_in(sd_c[g]),
         .valid_ff(sv_c[g+1]), .d_ff(sd_c[g+1]));
   end

   // Divider set-up: magnitudes shifted left by F, rounding bias added at the end.
   rmq_pkg::dv_data_type dfront;
   rmq_pkg::sq_data_type sq_o;
   logic [rmq_pkg::NUM_W-1:0] mag;
   always_comb begin
      sq_o = sd_c[NS];
      dfront.big = sq_o.big;
      dfront.root = sq_o.root;
      dfront.rem = '0;
      for (int k = 0; k < 3; k++) begin
         dfront.neg[k] = sq_o.num[k][rmq_pkg::NUM_W-1];
         mag = dfront.neg[k] ? -sq_o.num[k] : sq_o.num[k];
         dfront.quo[k] = rmq_pkg::DIV_N_W'({mag, {rmq_pkg::FRAC_BITS{1'b0}}});
      end
   end

   logic dv_c [ND+1];
   rmq_pkg::dv_data_type dd_c [ND+1];
   assign dv_c[0] = sv_c[NS];
   assign dd_c[0] = dfront;
   for (genvar g = 0; g < ND; g++) begin : g_dv
      rmq_div_cell u_cell (
         .clock(clock), .reset(reset), .en(en), .valid_in(dv_c[g]),
         .d_in(dd_c[g]), .valid_ff(dv_c[g+1]), .d_ff(dd_c[g+1]));
   end

   // Rounding: q + 1 when 2*remainder >= S (same as floor((n + S/2)/S), S even).
   rmq_pkg::dv_data_type dv_o;
   logic [3:0][15:0] res;
   logic [rmq_pkg::Q_W-1:0] qr;
   logic [rmq_pkg::DEN_W+1:0] rem2;
   logic [rmq_pkg::DEN_W+1:0] sden;
   int kk;
   always_comb begin
      dv_o = dd_c[ND];
      sden = {2'b00, dv_o.root, 1'b0};
      kk = 0;
      res = '0;
      qr = '0;
      rem2 = '0;
      for (int q = 0; q < 4; q++) begin
         if (q == int'(dv_o.big)) begin
            res[q] = 16'(dv_o.root >> 1);
         end else begin
            rem2 = {dv_o.rem[kk], 1'b0};
            qr = {1'b0, dv_o.quo[kk]} + rmq_pkg::Q_W'(rem2 >= sden);
            if (dv_o.root == '0) res[q] = '0;
            else res[q] = rmq_pkg::sat16(dv_o.neg[kk] ? -$signed({1'b0, qr})
                                                      : $signed({1'b0, qr}));
            kk = kk + 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_tvalid <= 1'b0;
      else if (en) rsp_tvalid <= dv_c[ND];
      if (en) rsp_tdata <= res;
   end
endmodule
`default_nettype wire

@@ sv/rmq_checker.sv @@
// Port-level checker for the rotation-matrix-to-quaternion core, with its bind.
`default_nettype none
module rmq_checker (
   input wire         clock,
   input wire         reset,
   input wire         req_tready,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [63:0]  rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while chain frozen");
   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result after reset");
endmodule

bind rotation_matrix_to_quaternion_core rmq_checker u_rmq_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));
`default_nettype wire

@@ tb/tb_rotation_matrix_to_quaternion_core.sv @@
// Testbench for the rotation-matrix-to-quaternion core: random and directed matrices, checked.
`timescale 1ns / 1ps
`default_nettype none
module tb_rotation_matrix_to_quaternion_core;
   localparam int ONE_Q = 1 << rmq_pkg::FRAC_BITS;
   localparam longint CYCLE_LIMIT = 400000;

   typedef logic signed [15:0] elem_type;
   typedef struct packed {
      elem_type m22, m21, m20, m12, m11, m10, m02, m01, m00;
   } matrix_type;
   typedef struct packed {
      elem_type z, y, x, w;
   } quat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [143:0] req_tdata = '0;
   logic req_taken = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;

   matrix_type pending_matrices[$];
   quat_type expected_quats[$];
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_cycles = 0;
   int mismatch_count = 0;
   int result_count = 0;
   int sent_count = 0;
   longint cycle_count = 0;

   rotation_matrix_to_quaternion_core DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   // Integer square root, floor.
   function automatic longint unsigned floor_sqrt(input longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      for (int i = 31; i >= 0; i--) begin
         b = res | (64'd1 << i);
         if (b * b <= n) begin
            res = b;
         end
      end
      return res;
   endfunction

   // Numerator * 2^F / S, rounded to nearest with ties away from zero.
   function automatic longint round_div(input longint num, input longint unsigned den);
      longint unsigned mag;
      longint unsigned q;
      if (den == 0) begin
         return 0;
      end
      mag = (num < 0 ? -num : num) << rmq_pkg::FRAC_BITS;
      q = (mag + den / 2) / den;
      return num < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic elem_type clamp16(input longint v);
      if (v > 32767) begin
         return 16'sh7FFF;
      end
      if (v < -32768) begin
         return 16'sh8000;
      end
      return elem_type'(v);
   endfunction

   // Expected quaternion for one matrix.
   function automatic quat_type matrix_to_quat(input matrix_type m);
      longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
      longint trace, r;
      longint n[4];
      longint unsigned root;
      int big;
      quat_type q;
      a00 = m.m00; a01 = m.m01; a02 = m.m02;
      a10 = m.m10; a11 = m.m11; a12 = m.m12;
      a20 = m.m20; a21 = m.m21; a22 = m.m22;
      trace = a00 + a11 + a22;
      if (trace > 0) begin
         r = trace + ONE_Q; big = 0;
         n[1] = a21 - a12; n[2] = a02 - a20; n[3] = a10 - a01;
      end else if (a00 > a11 && a00 > a22) begin
         r = ONE_Q + a00 - a11 - a22; big = 1;
         n[0] = a21 - a12; n[2] = a01 + a10; n[3] = a02 + a20;
      end else if (a11 > a22) begin
         r = ONE_Q + a11 - a00 - a22; big = 2;
         n[0] = a02 - a20; n[1] = a01 + a10; n[3] = a12 + a21;
      end else begin
         r = ONE_Q + a22 - a00 - a11; big = 3;
         n[0] = a10 - a01; n[1] = a02 + a20; n[2] = a12 + a21;
      end
      if (r < 0) begin
         r = 0;
      end
      root = floor_sqrt(longint'(r) << rmq_pkg::FRAC_BITS);
      n[big] = 0;
      q.w = big == 0 ? clamp16(root >> 1) : clamp16(round_div(n[0], 2 * root));
      q.x = big == 1 ? clamp16(root >> 1) : clamp16(round_div(n[1], 2 * root));
      q.y = big == 2 ? clamp16(root >> 1) : clamp16(round_div(n[2], 2 * root));
      q.z = big == 3 ? clamp16(root >> 1) : clamp16(round_div(n[3], 2 * root));
      return q;
   endfunction

   // Random element: mostly near a rotation's range, sometimes any value.
   function automatic elem_type rand_elem();
      case ($urandom_range(0, 3))
         0: return elem_type'($urandom);
         default: return elem_type'($signed($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
      endcase
   endfunction

   // Rough rotation: one dominant diagonal or a random diagonal, off-diagonals within +/-1.0.
   function automatic matrix_type rand_rotation_like();
      matrix_type m;
      int pick;
      m = '0;
      m.m01 = elem_type'($signed($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
      m.m10 = elem_type'($signed($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
      m.m02 = elem_type'($signed($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
      m.m20 = elem_type'($signed($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
      m.m12 = elem_type'($signed($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
      m.m21 = elem_type'($signed($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
      m.m00 = elem_type'($signed($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
      m.m11 = elem_type'($signed($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
      m.m22 = elem_type'($signed($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
      pick = $urandom_range(0, 3);
      if (pick == 1) begin
         m.m00 = elem_type'(ONE_Q - $urandom_range(0, 2000));
         m.m11 = elem_type'(-m.m00 + $urandom_range(0, 400) - 200);
         m.m22 = elem_type'(-m.m00 + $urandom_range(0, 400) - 200);
      end else if (pick == 2) begin
         m.m11 = elem_type'(ONE_Q - $urandom_range(0, 2000));
         m.m00 = elem_type'(-m.m11 + $urandom_range(0, 400) - 200);
         m.m22 = elem_type'(-m.m11 + $urandom_range(0, 400) - 200);
      end else if (pick == 3) begin
         m.m22 = elem_type'(ONE_Q - $urandom_range(0, 2000));
         m.m00 = elem_type'(-m.m22 + $urandom_range(0, 400) - 200);
         m.m11 = elem_type'(-m.m22 + $urandom_range(0, 400) - 200);
      end
      return m;
   endfunction

   // Driver: offers queued matrices, idling at random.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_matrices.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_matrices.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver readiness, with a counted hold-off.
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset && ($urandom_range(1, 100) > recv_stall_pct);
      end
   end

   // Input monitor: predicts each accepted matrix.
   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         expected_quats.insert(expected_quats.size(),
                               matrix_to_quat(matrix_type'(req_tdata)));
         sent_count <= sent_count + 1;
      end
   end

   // Output monitor: compares each quaternion with the oldest expectation.
   always @(posedge clock) begin
      quat_type got;
      quat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = quat_type'(rsp_tdata);
         result_count <= result_count + 1;
         if (expected_quats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected quaternion %h", got);
            end
         end else begin
            want = expected_quats.pop_front();
            if (got.w !== want.w || got.x !== want.x || got.y !== want.y
                || got.z !== want.z) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected w=%0d x=%0d y=%0d z=%0d, got w=%0d x=%0d y=%0d z=%0d",
                           want.w, want.x, want.y, want.z, got.w, got.x, got.y, got.z);
               end
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   task automatic load_and_drain(input int n_items, input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < n_items; i++) begin
         pending_matrices.insert(pending_matrices.size(), $urandom_range(0, 3) == 0 ?
            matrix_type'({rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                          rand_elem(), rand_elem(), rand_elem(), rand_elem()})
            : rand_rotation_like());
      end
      wait (pending_matrices.size() == 0 && !req_tvalid);
   endtask

   initial begin
      matrix_type m;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed cases: identity, the three axis flips, extremes and zero.
      m = '0; m.m00 = elem_type'(ONE_Q); m.m11 = elem_type'(ONE_Q); m.m22 = elem_type'(ONE_Q);
      pending_matrices.insert(pending_matrices.size(), m);
      m = '0; m.m00 = elem_type'(ONE_Q); m.m11 = elem_type'(-ONE_Q); m.m22 = elem_type'(-ONE_Q);
      pending_matrices.insert(pending_matrices.size(), m);
      m = '0; m.m00 = elem_type'(-ONE_Q); m.m11 = elem_type'(ONE_Q); m.m22 = elem_type'(-ONE_Q);
      pending_matrices.insert(pending_matrices.size(), m);
      m = '0; m.m00 = elem_type'(-ONE_Q); m.m11 = elem_type'(-ONE_Q); m.m22 = elem_type'(ONE_Q);
      pending_matrices.insert(pending_matrices.size(), m);
      pending_matrices.insert(pending_matrices.size(), matrix_type'('0));
      pending_matrices.insert(pending_matrices.size(), matrix_type'({9{16'h7FFF}}));
      pending_matrices.insert(pending_matrices.size(), matrix_type'({9{16'h8000}}));
      pending_matrices.insert(pending_matrices.size(), matrix_type'({9{16'hFFFF}}));
      pending_matrices.insert(pending_matrices.size(),
         matrix_type'({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
                       16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}));
      // Large diagonal with a large positive trace.
      m = '0; m.m00 = 16'sh7FFF; m.m11 = 16'sh7FFF; m.m22 = 16'sh8000;
      m.m01 = 16'sh7FFF; pending_matrices.insert(pending_matrices.size(), m);
      // Unit radicand with extreme off-diagonal sums: output saturation.
      m = '0; m.m12 = 16'sh8000; m.m21 = 16'sh8000; m.m02 = 16'sh7FFF; m.m20 = 16'sh7FFF;
      m.m10 = 16'sh7FFF; m.m01 = 16'sh8000;
      pending_matrices.insert(pending_matrices.size(), m);
      // Ties on the diagonal with zero trace.
      m = '0; m.m00 = 0; m.m11 = 0; m.m22 = 0; m.m10 = 100; m.m01 = -100;
      pending_matrices.insert(pending_matrices.size(), m);
      wait (pending_matrices.size() == 0 && !req_tvalid);

      load_and_drain(160, 0, 0);
      load_and_drain(160, 55, 0);
      load_and_drain(160, 0, 55);

      // Long receiver hold-off while the sender keeps pushing.
      hold_off_cycles = 300;
      load_and_drain(60, 0, 0);
      load_and_drain(140, 26, 26);

      wait (expected_quats.size() == 0);
      repeat (120) @(posedge clock);
      $display("%0d matrices sent, %0d quaternions checked across all branches and stall phases",
               sent_count, result_count);
      if (mismatch_count == 0 && expected_quats.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("simulation failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
